// ===== src/lock_manager_deadlock_refuse_core_assert.svh =====
// ----------------------------------------------------------------------------
// Lock manager assertion macros
// Shared assertion wrappers for the lock manager checker.
// ----------------------------------------------------------------------------
`ifndef LOCK_MANAGER_DEADLOCK_REFUSE_CORE_ASSERT_SVH
`define LOCK_MANAGER_DEADLOCK_REFUSE_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define LMDR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LMDR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lmdr_pkg.sv =====
// ----------------------------------------------------------------------------
// Lock manager package
// Sizes, codes and a helper function shared by the lock manager files.
// ----------------------------------------------------------------------------
package lmdr_pkg;

   localparam int NUM_LOCKS   = 16;
   localparam int NUM_THREADS = 16;

   localparam int ID_W      = 4;
   localparam int STATUS_W  = 3;
   localparam int LOCK_W    = $clog2(NUM_LOCKS);
   localparam int THREAD_W  = $clog2(NUM_THREADS);
   localparam int COUNT_W   = $clog2(NUM_THREADS + 1);
   localparam int STEP_W    = $clog2(NUM_LOCKS);
   localparam int RAM_DEPTH = NUM_LOCKS * NUM_THREADS;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_LOCKS - 1);

   localparam logic FUNC_LOCK   = 1'b0;
   localparam logic FUNC_UNLOCK = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_QUEUED   = 3'd1,
      STATUS_REFUSED  = 3'd2,
      STATUS_RELEASED = 3'd3,
      STATUS_BAD      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_WALK,
      SEQ_HAND
   } seq_state_type;

   typedef enum logic [2:0] {
      ACT_BAD,
      ACT_GRANT,
      ACT_ENQUEUE,
      ACT_FREE,
      ACT_HANDOVER
   } action_type;

   typedef struct packed {
      logic [THREAD_W-1:0] head;
      logic [THREAD_W-1:0] tail;
      logic [COUNT_W-1:0]  count;
   } queue_ptr_type;

   function automatic logic [THREAD_W-1:0] ring_next(input logic [THREAD_W-1:0] p);
      logic [THREAD_W-1:0] r;
      if (p == THREAD_W'(NUM_THREADS - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== src/lmdr_if.sv =====
// ----------------------------------------------------------------------------
// Lock manager channel interfaces
// Valid/ready channels for lock requests and their results.
// ----------------------------------------------------------------------------
interface lmdr_req_if import lmdr_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            func;
   logic [ID_W-1:0] thread_id;
   logic [ID_W-1:0] lock_id;

   modport source (output valid, func, thread_id, lock_id, input ready);
   modport sink   (input valid, func, thread_id, lock_id, output ready);
endinterface

interface lmdr_rsp_if import lmdr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                wake_valid;
   logic [ID_W-1:0]     wake_thread;

   modport source (output valid, status, wake_valid, wake_thread, input ready);
   modport sink   (input valid, status, wake_valid, wake_thread, output ready);
endinterface

// ===== src/lmdr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lmdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lock_manager_deadlock_refuse_core.sv =====
// ----------------------------------------------------------------------------
// Lock manager with deadlock refusal
// Grants, queues and releases locks, and refuses a request that would close
// a cycle in the wait-for graph. Waiters are handed a lock in FIFO order.
//
// Channel   Direction  Handshake        Payload
// req_chan  in         valid / ready    func, thread_id, lock_id
// rsp_chan  out        valid / ready    status, wake_valid, wake_thread
//
// A grant, a refusal for a bad id and a release without waiters finish in the execute state.
// A request on a held lock walks the wait-for chain one lock per cycle through
// the owner and wait tables.
// A release with hand-over makes one read of the waiter RAM.
// Reset clears the tables at once; the waiter RAM needs no clearing.
// A result that is not taken holds the sequencer at its last step; a new
// request is taken as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
module lock_manager_deadlock_refuse_core import lmdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lmdr_req_if.sink    req_chan,
   lmdr_rsp_if.source  rsp_chan
);

   seq_state_type       state_ff, state_in;
   logic                func_ff, func_in;
   logic [ID_W-1:0]     tid_ff, tid_in;
   logic [ID_W-1:0]     lid_ff, lid_in;
   logic [LOCK_W-1:0]   cur_ff, cur_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                owner_valid_ff  [NUM_LOCKS];
   logic                owner_valid_in  [NUM_LOCKS];
   logic [THREAD_W-1:0] owner_thread_ff [NUM_LOCKS];
   logic [THREAD_W-1:0] owner_thread_in [NUM_LOCKS];
   logic                wait_valid_ff   [NUM_THREADS];
   logic                wait_valid_in   [NUM_THREADS];
   logic [LOCK_W-1:0]   wait_lock_ff    [NUM_THREADS];
   logic [LOCK_W-1:0]   wait_lock_in    [NUM_THREADS];
   queue_ptr_type       queue_ff        [NUM_LOCKS];
   queue_ptr_type       queue_in        [NUM_LOCKS];

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_wv_ff, rsp_wv_in;
   logic [ID_W-1:0]     rsp_wt_ff, rsp_wt_in;

   logic                accept;
   logic                out_free;
   logic                ids_ok;
   logic [LOCK_W-1:0]   lk;
   logic [THREAD_W-1:0] th;
   queue_ptr_type       q;
   action_type          action;

   logic                walk_owned;
   logic [THREAD_W-1:0] walk_thread;
   logic                walk_waits;
   logic [LOCK_W-1:0]   walk_next;
   logic                walk_closes;
   logic                walk_open;

   logic                finish;
   status_type          fin_status;
   logic                fin_wv;
   logic [ID_W-1:0]     fin_wt;

   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [LOCK_W+THREAD_W-1:0] ram_wr_addr;
   logic [LOCK_W+THREAD_W-1:0] ram_rd_addr;
   logic [THREAD_W-1:0] ram_rd_data;
   logic [THREAD_W-1:0] wake;

   lmdr_ram #(
      .WIDTH (THREAD_W),
      .DEPTH (RAM_DEPTH)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (th),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign lk       = lid_ff[LOCK_W-1:0];
   assign th       = tid_ff[THREAD_W-1:0];
   assign q        = queue_ff[lk];
   assign wake     = ram_rd_data;

   assign req_chan.ready       = (state_ff == SEQ_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.wake_valid  = rsp_wv_ff;
   assign rsp_chan.wake_thread = rsp_wt_ff;

   // Decode of a new request against the tables.
   always_comb begin
      ids_ok = (int'(tid_ff) < NUM_THREADS) && (int'(lid_ff) < NUM_LOCKS);
      action = ACT_BAD;
      if (ids_ok) begin
         if (func_ff == FUNC_LOCK) begin
            if (wait_valid_ff[th]) begin
               action = ACT_BAD;
            end else if (!owner_valid_ff[lk]) begin
               action = ACT_GRANT;
            end else if (int'(q.count) >= NUM_THREADS) begin
               action = ACT_BAD;
            end else begin
               action = ACT_ENQUEUE;
            end
         end else begin
            if (!owner_valid_ff[lk] || owner_thread_ff[lk] != th) begin
               action = ACT_BAD;
            end else if (q.count == '0) begin
               action = ACT_FREE;
            end else begin
               action = ACT_HANDOVER;
            end
         end
      end
   end

   // One step of the wait-for walk from the current lock.
   always_comb begin
      walk_owned  = owner_valid_ff[cur_ff];
      walk_thread = owner_thread_ff[cur_ff];
      walk_waits  = wait_valid_ff[walk_thread];
      walk_next   = wait_lock_ff[walk_thread];
      walk_closes = walk_owned && walk_waits && (walk_next == lk);
      walk_open   = !walk_owned || !walk_waits || (step_ff == LAST_STEP);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (out_free) begin
               unique case (action)
                  ACT_ENQUEUE:  state_in = SEQ_WALK;
                  ACT_HANDOVER: state_in = SEQ_HAND;
                  default:      state_in = SEQ_IDLE;
               endcase
            end
         end
         SEQ_WALK: begin
            if (walk_closes || walk_open) begin
               if (out_free) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         SEQ_HAND: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Table updates, RAM control and results.
   always_comb begin
      func_in         = func_ff;
      tid_in          = tid_ff;
      lid_in          = lid_ff;
      cur_in          = cur_ff;
      step_in         = step_ff;
      owner_valid_in  = owner_valid_ff;
      owner_thread_in = owner_thread_ff;
      wait_valid_in   = wait_valid_ff;
      wait_lock_in    = wait_lock_ff;
      queue_in        = queue_ff;
      finish          = 1'b0;
      fin_status      = STATUS_BAD;
      fin_wv          = 1'b0;
      fin_wt          = '0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = {lk, q.tail};
      ram_rd_en       = 1'b0;
      ram_rd_addr     = {lk, q.head};

      if (accept) begin
         func_in = req_chan.func;
         tid_in  = req_chan.thread_id;
         lid_in  = req_chan.lock_id;
      end

      unique case (state_ff)
         SEQ_EXEC: begin
            if (out_free) begin
               unique case (action)
                  ACT_GRANT: begin
                     owner_valid_in[lk]  = 1'b1;
                     owner_thread_in[lk] = th;
                     finish              = 1'b1;
                     fin_status          = STATUS_GRANTED;
                  end
                  ACT_ENQUEUE: begin
                     ram_wr_en         = 1'b1;
                     wait_valid_in[th] = 1'b1;
                     wait_lock_in[th]  = lk;
                     cur_in            = lk;
                     step_in           = '0;
                  end
                  ACT_FREE: begin
                     owner_valid_in[lk]  = 1'b0;
                     owner_thread_in[lk] = '0;
                     finish              = 1'b1;
                     fin_status          = STATUS_RELEASED;
                  end
                  ACT_HANDOVER: begin
                     ram_rd_en = 1'b1;
                  end
                  default: begin
                     finish     = 1'b1;
                     fin_status = STATUS_BAD;
                  end
               endcase
            end
         end
         SEQ_WALK: begin
            if (walk_closes) begin
               if (out_free) begin
                  wait_valid_in[th] = 1'b0;
                  wait_lock_in[th]  = '0;
                  finish            = 1'b1;
                  fin_status        = STATUS_REFUSED;
               end
            end else if (walk_open) begin
               if (out_free) begin
                  queue_in[lk].tail  = ring_next(q.tail);
                  queue_in[lk].count = q.count + 1'b1;
                  finish             = 1'b1;
                  fin_status         = STATUS_QUEUED;
               end
            end else begin
               cur_in  = walk_next;
               step_in = step_ff + 1'b1;
            end
         end
         SEQ_HAND: begin
            if (out_free) begin
               owner_thread_in[lk] = wake;
               wait_valid_in[wake] = 1'b0;
               wait_lock_in[wake]  = '0;
               queue_in[lk].head   = ring_next(q.head);
               queue_in[lk].count  = q.count - 1'b1;
               finish              = 1'b1;
               fin_status          = STATUS_RELEASED;
               fin_wv              = 1'b1;
               fin_wt              = ID_W'(wake);
            end
         end
         default: begin
         end
      endcase

      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_wv_in     = fin_wv;
         rsp_wt_in     = fin_wt;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
         rsp_status_in = rsp_status_ff;
         rsp_wv_in     = rsp_wv_ff;
         rsp_wt_in     = rsp_wt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LOCKS; i++) begin
            owner_valid_ff[i]  <= 1'b0;
            owner_thread_ff[i] <= '0;
            queue_ff[i]        <= '0;
         end
         for (int i = 0; i < NUM_THREADS; i++) begin
            wait_valid_ff[i] <= 1'b0;
            wait_lock_ff[i]  <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         owner_valid_ff  <= owner_valid_in;
         owner_thread_ff <= owner_thread_in;
         queue_ff        <= queue_in;
         wait_valid_ff   <= wait_valid_in;
         wait_lock_ff    <= wait_lock_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      tid_ff        <= tid_in;
      lid_ff        <= lid_in;
      cur_ff        <= cur_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_wt_ff     <= rsp_wt_in;
   end

endmodule

// ===== src/lmdr_checker.sv =====
// ----------------------------------------------------------------------------
// Lock manager port checker
// Watches the request and result channels of the lock manager over time.
// ----------------------------------------------------------------------------
`include "lock_manager_deadlock_refuse_core_assert.svh"

module lmdr_checker import lmdr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_wake_valid,
   input logic [ID_W-1:0]     rsp_wake_thread
);

   `LMDR_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $fell(reset) |-> !rsp_valid, "Result valid right after reset.")

   `LMDR_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready, "Request taken while an earlier one is at work.")

   `LMDR_ASSERT(a_rsp_holds, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "Result dropped before its transfer.")

   `LMDR_ASSERT(a_wake_on_release, clock, reset, (rsp_valid && rsp_wake_valid) |-> (rsp_status == STATUS_RELEASED), "Hand-over reported without a release.")

   `LMDR_ASSERT(a_wake_thread_zero, clock, reset, (rsp_valid && !rsp_wake_valid) |-> (rsp_wake_thread == '0), "Wake thread set without a hand-over.")

endmodule

bind lock_manager_deadlock_refuse_core lmdr_checker u_lmdr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_wake_valid  (rsp_chan.wake_valid),
   .rsp_wake_thread (rsp_chan.wake_thread)
);
